/* rtl/vertex_attribute_quantizer_unit_defines.svh */
// Assertion macros for the vertex attribute quantizer.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef VERTEX_ATTRIBUTE_QUANTIZER_UNIT_DEFINES_SVH
`define VERTEX_ATTRIBUTE_QUANTIZER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define VAQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define VAQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/vaq_pkg.sv */
// Shared types, constants and lane setup functions for the vertex quantizer.
// No dependencies; used by every module of the block.
package vaq_pkg;

    localparam int NLANE   = 7;    // three position lanes, four octahedral lanes
    localparam int NPOS    = 3;
    localparam int NDIV    = 16;   // quotient bits, one per divider stage
    localparam int NSTG    = NDIV + 4;
    localparam int REMW    = 34;
    localparam int NUMW    = 50;
    localparam int CIDXW   = 3;

    localparam logic [CIDXW-1:0] REG_MIN_X = 3'd0;
    localparam logic [CIDXW-1:0] REG_MIN_Y = 3'd1;
    localparam logic [CIDXW-1:0] REG_MIN_Z = 3'd2;
    localparam logic [CIDXW-1:0] REG_EXT_X = 3'd3;
    localparam logic [CIDXW-1:0] REG_EXT_Y = 3'd4;
    localparam logic [CIDXW-1:0] REG_EXT_Z = 3'd5;

    localparam logic [15:0] UNORM_MAX = 16'hFFFF;

    typedef struct packed {
        logic [NPOS-1:0][31:0] mn;
        logic [NPOS-1:0][31:0] ext;
    } t_cfg;

    typedef struct packed {
        logic [NPOS-1:0][31:0] pos;
        logic [2:0][15:0]      nrm;
        logic [2:0][15:0]      tan;
        logic                  hand;
    } t_in;

    typedef struct packed {
        logic [31:0] ud;
        logic        zero;
        logic        sat;
    } t_posm;

    typedef struct packed {
        logic [16:0] mag_u;
        logic [16:0] mag_v;
        logic [16:0] l1;
        logic        neg_u;
        logic        neg_v;
        logic        zero;
    } t_octm;

    typedef struct packed {
        t_posm [NPOS-1:0] pos;
        t_octm [1:0]      oct;
        logic             hand;
    } t_mid;

    typedef struct packed {
        logic [REMW-1:0] rem;
        logic [REMW-1:0] den;
        logic [15:0]     sh;
        logic            zero;
        logic            sat;
        logic            neg;
    } t_lane;

    typedef struct packed {
        t_lane [NLANE-1:0] lane;
        logic              hand;
    } t_div;

    typedef struct packed {
        logic [NPOS-1:0][15:0] packed_xyz;
        logic [3:0][15:0]      oct;
        logic                  hand;
    } t_out;

    // Offset from the box minimum, with below-box and beyond-box flags
    function automatic t_posm pos_mid(logic [31:0] p, logic [31:0] mn, logic [31:0] ext);
        logic [32:0] d;
        t_posm       m;
        d      = {p[31], p} - {mn[31], mn};
        m.zero = (ext == 32'd0) || d[32] || (d == 33'd0);
        m.sat  = ({1'b0, ext} <= d);
        m.ud   = d[31:0];
        return m;
    endfunction

    // L1 norm, octahedral fold and signs of one vector
    function automatic t_octm oct_mid(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        logic [16:0] ax;
        logic [16:0] ay;
        logic [16:0] az;
        logic [16:0] l1;
        t_octm       m;
        ax      = x[15] ? 17'(-{x[15], x}) : {1'b0, x};
        ay      = y[15] ? 17'(-{y[15], y}) : {1'b0, y};
        az      = z[15] ? 17'(-{z[15], z}) : {1'b0, z};
        l1      = ax + ay + az;
        m.l1    = l1;
        m.zero  = (l1 == 17'd0);
        m.neg_u = x[15];
        m.neg_v = y[15];
        if (z[15]) begin
            m.mag_u = l1 - ay;
            m.mag_v = l1 - ax;
        end else begin
            m.mag_u = ax;
            m.mag_v = ay;
        end
        return m;
    endfunction

    // Numerator 2*ud*65535 + ext over 2*ext
    function automatic t_lane pos_lane(t_posm m, logic [31:0] ext);
        logic [NUMW-1:0] n;
        t_lane           l;
        n      = ({18'd0, m.ud} << 17) - ({18'd0, m.ud} << 1) + {18'd0, ext};
        l.rem  = n[NUMW-1:16];
        l.sh   = n[15:0];
        l.den  = {1'b0, ext, 1'b0};
        l.zero = m.zero;
        l.sat  = m.sat;
        l.neg  = 1'b0;
        return l;
    endfunction

    // Numerator 2*mag*32767 + l1 over 2*l1
    function automatic t_lane oct_lane(logic [16:0] mag, logic [16:0] l1, logic neg,
                                       logic zero);
        logic [NUMW-1:0] n;
        t_lane           l;
        n      = ({33'd0, mag} << 16) - ({33'd0, mag} << 1) + {33'd0, l1};
        l.rem  = n[NUMW-1:16];
        l.sh   = n[15:0];
        l.den  = {16'd0, l1, 1'b0};
        l.zero = zero;
        l.sat  = 1'b0;
        l.neg  = neg;
        return l;
    endfunction

endpackage

/* rtl/vaq_cfg.sv */
// Box configuration registers of the vertex quantizer.
// Depends on vaq_pkg.
module vaq_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [vaq_pkg::CIDXW-1:0] i_cfg_idx,
    input  logic [31:0]               i_cfg_data,
    output vaq_pkg::t_cfg             o_cfg
);
    import vaq_pkg::*;

    t_cfg r_cfg;

    // Write the addressed register, drop writes past the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MIN_X: r_cfg.mn[0]  <= i_cfg_data;
                REG_MIN_Y: r_cfg.mn[1]  <= i_cfg_data;
                REG_MIN_Z: r_cfg.mn[2]  <= i_cfg_data;
                REG_EXT_X: r_cfg.ext[0] <= i_cfg_data;
                REG_EXT_Y: r_cfg.ext[1] <= i_cfg_data;
                REG_EXT_Z: r_cfg.ext[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/vaq_front.sv */
// Front stages: input capture, offset/L1 preparation, divider operand setup.
// Depends on vaq_pkg.
module vaq_front (
    input  logic          i_clk,
    input  logic          i_en,
    input  vaq_pkg::t_in  i_in,
    input  vaq_pkg::t_cfg i_cfg,
    output vaq_pkg::t_div o_div
);
    import vaq_pkg::*;

    t_in  r_in;
    t_mid r_mid;
    t_div r_div;
    t_mid n_mid;
    t_div n_div;

    // Offsets, flags, L1 norms and fold
    always_comb begin
        for (int i = 0; i < NPOS; i++) begin
            n_mid.pos[i] = pos_mid(r_in.pos[i], i_cfg.mn[i], i_cfg.ext[i]);
        end
        n_mid.oct[0] = oct_mid(r_in.nrm[0], r_in.nrm[1], r_in.nrm[2]);
        n_mid.oct[1] = oct_mid(r_in.tan[0], r_in.tan[1], r_in.tan[2]);
        n_mid.hand   = r_in.hand;
    end

    // Numerators and denominators for every lane
    always_comb begin
        for (int i = 0; i < NPOS; i++) begin
            n_div.lane[i] = pos_lane(r_mid.pos[i], i_cfg.ext[i]);
        end
        for (int j = 0; j < 2; j++) begin
            n_div.lane[NPOS + 2*j]     = oct_lane(r_mid.oct[j].mag_u, r_mid.oct[j].l1,
                                                  r_mid.oct[j].neg_u, r_mid.oct[j].zero);
            n_div.lane[NPOS + 2*j + 1] = oct_lane(r_mid.oct[j].mag_v, r_mid.oct[j].l1,
                                                  r_mid.oct[j].neg_v, r_mid.oct[j].zero);
        end
        n_div.hand = r_mid.hand;
    end

    // Advance all three stages together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_in  <= i_in;
            r_mid <= n_mid;
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

/* rtl/vaq_div_step.sv */
// One restoring division step on every lane: one quotient bit per lane.
// Depends on vaq_pkg.
module vaq_div_step (
    input  vaq_pkg::t_div i_div,
    output vaq_pkg::t_div o_div
);
    import vaq_pkg::*;

    // Shift in the next numerator bit, subtract when it fits
    always_comb begin
        logic [REMW:0] t;
        logic [REMW:0] dd;
        o_div = i_div;
        for (int i = 0; i < NLANE; i++) begin
            t  = {i_div.lane[i].rem, i_div.lane[i].sh[15]};
            dd = {1'b0, i_div.lane[i].den};
            if (t >= dd) begin
                o_div.lane[i].rem = REMW'(t - dd);
                o_div.lane[i].sh  = {i_div.lane[i].sh[14:0], 1'b1};
            end else begin
                o_div.lane[i].rem = t[REMW-1:0];
                o_div.lane[i].sh  = {i_div.lane[i].sh[14:0], 1'b0};
            end
        end
    end

endmodule

/* rtl/vertex_attribute_quantizer_unit.sv */
// Vertex attribute quantizer: one vertex in, one packed record out, one vertex per cycle
// unless stalled. Stages: input capture, offset/L1 preparation, operand setup, sixteen
// restoring divider stages (one quotient bit each, all seven lanes side by side) and an
// output register. The whole pipeline stalls together while the output is held. The user
// must write box registers via the plain write port while the block is idle; unenforced.
module vertex_attribute_quantizer_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [vaq_pkg::CIDXW-1:0] i_cfg_idx,
    input  logic [31:0]               i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [31:0]        i_position_x,
    input  logic signed [31:0]        i_position_y,
    input  logic signed [31:0]        i_position_z,
    input  logic signed [15:0]        i_normal_x,
    input  logic signed [15:0]        i_normal_y,
    input  logic signed [15:0]        i_normal_z,
    input  logic signed [15:0]        i_tangent_x,
    input  logic signed [15:0]        i_tangent_y,
    input  logic signed [15:0]        i_tangent_z,
    input  logic signed [15:0]        i_tangent_sign,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [15:0]               o_packed_x,
    output logic [15:0]               o_packed_y,
    output logic [15:0]               o_packed_z,
    output logic signed [15:0]        o_oct_normal_u,
    output logic signed [15:0]        o_oct_normal_v,
    output logic signed [15:0]        o_oct_tangent_u,
    output logic signed [15:0]        o_oct_tangent_v,
    output logic                      o_handedness
);
    import vaq_pkg::*;

`include "vertex_attribute_quantizer_unit_defines.svh"

    t_cfg            w_cfg;
    t_in             w_in;
    logic            w_en;
    logic [NSTG-1:0] r_vld;
    t_div            w_stage [NDIV+1];
    t_div            w_step  [NDIV];
    t_div            r_step  [NDIV];
    t_out            r_out;
    t_out            n_out;

    vaq_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Global advance: hold everything while a result waits
    assign w_en    = !(r_vld[NSTG-1] && i_stall);
    assign o_stall = !w_en;

    assign w_in.pos  = {i_position_z, i_position_y, i_position_x};
    assign w_in.nrm  = {i_normal_z, i_normal_y, i_normal_x};
    assign w_in.tan  = {i_tangent_z, i_tangent_y, i_tangent_x};
    assign w_in.hand = !i_tangent_sign[15];

    vaq_front u_front (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_in  (w_in),
        .i_cfg (w_cfg),
        .o_div (w_stage[0])
    );

    // Divider pipeline, one quotient bit per stage
    for (genvar k = 0; k < NDIV; k++) begin : g_div
        vaq_div_step u_step (
            .i_div (w_stage[k]),
            .o_div (w_step[k])
        );

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_step[k] <= w_step[k];
            end
        end

        assign w_stage[k+1] = r_step[k];
    end

    // Apply special cases and signs
    always_comb begin
        t_div d;
        d = w_stage[NDIV];
        for (int i = 0; i < NPOS; i++) begin
            if (d.lane[i].zero) begin
                n_out.packed_xyz[i] = '0;
            end else if (d.lane[i].sat) begin
                n_out.packed_xyz[i] = UNORM_MAX;
            end else begin
                n_out.packed_xyz[i] = d.lane[i].sh;
            end
        end
        for (int j = 0; j < 4; j++) begin
            if (d.lane[NPOS + j].zero) begin
                n_out.oct[j] = '0;
            end else if (d.lane[NPOS + j].neg) begin
                n_out.oct[j] = 16'(-d.lane[NPOS + j].sh);
            end else begin
                n_out.oct[j] = d.lane[NPOS + j].sh;
            end
        end
        n_out.hand = d.hand;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    assign o_valid         = r_vld[NSTG-1];
    assign o_packed_x      = r_out.packed_xyz[0];
    assign o_packed_y      = r_out.packed_xyz[1];
    assign o_packed_z      = r_out.packed_xyz[2];
    assign o_oct_normal_u  = r_out.oct[0];
    assign o_oct_normal_v  = r_out.oct[1];
    assign o_oct_tangent_u = r_out.oct[2];
    assign o_oct_tangent_v = r_out.oct[3];
    assign o_handedness    = r_out.hand;

    `VAQ_ASSERT_NOW(a_stall_only_when_full, o_stall, o_valid, "stall without a waiting result")
    `VAQ_ASSERT_NOW(a_normal_snorm_range, o_valid,
        (o_oct_normal_u != 16'h8000) && (o_oct_normal_v != 16'h8000),
        "octahedral normal outside snorm16 range")
    `VAQ_ASSERT_NOW(a_tangent_snorm_range, o_valid,
        (o_oct_tangent_u != 16'h8000) && (o_oct_tangent_v != 16'h8000),
        "octahedral tangent outside snorm16 range")
    `VAQ_ASSERT_NEXT(a_stall_holds_result, o_valid && i_stall, o_valid && $stable(r_out),
        "held result changed under stall")

endmodule

/* bench/vertex_attribute_quantizer_unit_checker.sv */
// Checker for the vertex attribute quantizer: watches both channels, predicts each record.
// Depends on vaq_pkg for the register index constants; tracks box registers on its own.
`timescale 1ns / 100ps

module vertex_attribute_quantizer_unit_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  logic signed [31:0] i_px,
    input  logic signed [31:0] i_py,
    input  logic signed [31:0] i_pz,
    input  logic signed [15:0] i_nx,
    input  logic signed [15:0] i_ny,
    input  logic signed [15:0] i_nz,
    input  logic signed [15:0] i_tx,
    input  logic signed [15:0] i_ty,
    input  logic signed [15:0] i_tz,
    input  logic signed [15:0] i_tw,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [15:0]        i_qx,
    input  logic [15:0]        i_qy,
    input  logic [15:0]        i_qz,
    input  logic [15:0]        i_nu,
    input  logic [15:0]        i_nv,
    input  logic [15:0]        i_tu,
    input  logic [15:0]        i_tv,
    input  logic               i_hand,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_records
);
    import vaq_pkg::*;

    typedef struct packed {
        logic [15:0] qx, qy, qz, nu, nv, tu, tv;
        logic        hand;
    } t_record;

    logic signed [31:0] box_min [3];
    logic [31:0]        box_ext [3];
    t_record            expected_records [$];

    // Map one position component into its box as unorm16
    function automatic logic [15:0] unorm_pos(logic signed [31:0] p, logic signed [31:0] mn,
                                             logic [31:0] ext);
        longint d;
        longint unsigned ud;
        d = longint'(p) - longint'(mn);
        if (ext == 0 || d <= 0) return 16'd0;
        ud = d;
        if (ud >= ext) return 16'hFFFF;
        return 16'((2 * ud * 65535 + ext) / (2 * longint'(ext)));
    endfunction

    function automatic logic [15:0] snorm(logic neg, longint mag, longint den);
        longint q;
        q = (2 * mag * 32767 + den) / (2 * den);
        if (q > 32767) q = 32767;
        return neg ? 16'(-q) : 16'(q);
    endfunction

    // Fold a vector onto the octahedron and round both coordinates
    function automatic logic [31:0] oct_pair(logic signed [15:0] x, logic signed [15:0] y,
                                             logic signed [15:0] z);
        longint ax, ay, az, l1;
        ax = x < 0 ? -longint'(x) : longint'(x);
        ay = y < 0 ? -longint'(y) : longint'(y);
        az = z < 0 ? -longint'(z) : longint'(z);
        l1 = ax + ay + az;
        if (l1 == 0) return 32'd0;
        if (z >= 0) return {snorm(x < 0, ax, l1), snorm(y < 0, ay, l1)};
        return {snorm(x < 0, l1 - ay, l1), snorm(y < 0, l1 - ax, l1)};
    endfunction

    task automatic report(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    // Track registers, predict on input transfers, compare on output transfers
    always @(posedge i_clk) begin
        t_record r;
        t_record e;
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                box_min[i] = 0;
                box_ext[i] = 0;
            end
            expected_records.delete();
            o_errors  = 0;
            o_records = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MIN_X: box_min[0] = i_cfg_data;
                    REG_MIN_Y: box_min[1] = i_cfg_data;
                    REG_MIN_Z: box_min[2] = i_cfg_data;
                    REG_EXT_X: box_ext[0] = i_cfg_data;
                    REG_EXT_Y: box_ext[1] = i_cfg_data;
                    REG_EXT_Z: box_ext[2] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                r = {i_qx, i_qy, i_qz, i_nu, i_nv, i_tu, i_tv, i_hand};
                o_records++;
                if (expected_records.size() == 0) begin
                    $display("unexpected record at %0t", $realtime);
                    o_errors++;
                end else begin
                    e = expected_records.pop_front();
                    if (r.qx != e.qx) report("packed_x", r.qx, e.qx);
                    if (r.qy != e.qy) report("packed_y", r.qy, e.qy);
                    if (r.qz != e.qz) report("packed_z", r.qz, e.qz);
                    if (r.nu != e.nu) report("oct_normal_u", r.nu, e.nu);
                    if (r.nv != e.nv) report("oct_normal_v", r.nv, e.nv);
                    if (r.tu != e.tu) report("oct_tangent_u", r.tu, e.tu);
                    if (r.tv != e.tv) report("oct_tangent_v", r.tv, e.tv);
                    if (r.hand != e.hand) report("handedness", 16'(r.hand), 16'(e.hand));
                end
            end
            if (i_valid && !i_in_stall) begin
                e.qx = unorm_pos(i_px, box_min[0], box_ext[0]);
                e.qy = unorm_pos(i_py, box_min[1], box_ext[1]);
                e.qz = unorm_pos(i_pz, box_min[2], box_ext[2]);
                {e.nu, e.nv} = oct_pair(i_nx, i_ny, i_nz);
                {e.tu, e.tv} = oct_pair(i_tx, i_ty, i_tz);
                e.hand = !i_tw[15];
                expected_records = {expected_records, e};
            end
        end
        o_pending = expected_records.size();
    end
endmodule

/* bench/vertex_attribute_quantizer_unit_test.sv */
// Testbench top for the vertex attribute quantizer: clock, reset, stimulus and verdict.
// Depends on vaq_pkg, the block itself and vertex_attribute_quantizer_unit_checker.
`timescale 1ns / 100ps

module vertex_attribute_quantizer_unit_test;
    import vaq_pkg::*;

    // Index past the register list, writes to it are dropped
    localparam logic [2:0] REG_NONE = 3'd7;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_idx = '0;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [31:0] px = '0, py = '0, pz = '0;
    logic signed [15:0] nx = '0, ny = '0, nz = '0, tx = '0, ty = '0, tz = '0, tw = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [15:0]        qx, qy, qz, nu, nv, tu, tv;
    logic               hand;
    int                 errors, pending, records;
    int                 stall_mode = 0;     // 0 random, 1 long hold-off, 2 none
    int                 vertices = 0;

    always #5 clk = ~clk;

    vertex_attribute_quantizer_unit dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_valid(in_valid), .o_stall(in_stall),
        .i_position_x(px), .i_position_y(py), .i_position_z(pz),
        .i_normal_x(nx), .i_normal_y(ny), .i_normal_z(nz),
        .i_tangent_x(tx), .i_tangent_y(ty), .i_tangent_z(tz), .i_tangent_sign(tw),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_packed_x(qx), .o_packed_y(qy), .o_packed_z(qz),
        .o_oct_normal_u(nu), .o_oct_normal_v(nv),
        .o_oct_tangent_u(tu), .o_oct_tangent_v(tv), .o_handedness(hand)
    );

    vertex_attribute_quantizer_unit_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_valid(in_valid), .i_in_stall(in_stall),
        .i_px(px), .i_py(py), .i_pz(pz), .i_nx(nx), .i_ny(ny), .i_nz(nz),
        .i_tx(tx), .i_ty(ty), .i_tz(tz), .i_tw(tw),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_qx(qx), .i_qy(qy), .i_qz(qz), .i_nu(nu), .i_nv(nv), .i_tu(tu), .i_tv(tv),
        .i_hand(hand), .o_errors(errors), .o_pending(pending), .o_records(records)
    );

    // Receiver stall pattern: random, a long hold-off, or open
    always @(negedge clk) begin
        if (stall_mode == 1) out_stall <= 1'b1;
        else if (stall_mode == 2) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(0, 3) == 0);
    end

    // Hold off the receiver for a long stretch, counted here
    task automatic hold_receiver(int cycles);
        stall_mode = 1;
        repeat (cycles) @(posedge clk);
        stall_mode = 0;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Drop valid right away, then wait for every expected record
    task automatic drain;
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic set_box(logic [31:0] mx, my, mz, ex, ey, ez);
        write_reg(REG_MIN_X, mx);
        write_reg(REG_MIN_Y, my);
        write_reg(REG_MIN_Z, mz);
        write_reg(REG_EXT_X, ex);
        write_reg(REG_EXT_Y, ey);
        write_reg(REG_EXT_Z, ez);
    endtask

    // Offer one vertex and hold it until transferred; valid stays high across items
    task automatic send_vertex(logic [31:0] a, b, c, logic [15:0] n0, n1, n2, t0, t1, t2, w);
        px <= a; py <= b; pz <= c;
        nx <= n0; ny <= n1; nz <= n2;
        tx <= t0; ty <= t1; tz <= t2; tw <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        vertices++;
        @(negedge clk);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'd0;
            3: return 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    // Position mostly inside the box, sometimes anywhere
    function automatic logic [31:0] rand_pos(logic [31:0] mn, logic [31:0] ext);
        logic [31:0] off;
        if ($urandom_range(0, 3) == 0) return $urandom;
        off = (ext == 32'hFFFFFFFF) ? $urandom : ($urandom % (ext + 32'd1));
        return mn + off - 32'd4 + $urandom_range(0, 8);
    endfunction

    task automatic random_vertices(int count, logic [31:0] mn, logic [31:0] ext);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 5) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            send_vertex(rand_pos(mn, ext), rand_pos(mn, ext), rand_pos(mn, ext),
                        rand_comp(), rand_comp(), rand_comp(),
                        rand_comp(), rand_comp(), rand_comp(), rand_comp());
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset box (zero extents), then fixed box
        send_vertex(32'd5, 32'h80000000, 32'h7FFFFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                    16'd0, 16'd0);
        drain();
        set_box(32'hFFFF0000, 32'h80000000, 32'd0, 32'h00020000, 32'hFFFFFFFF, 32'd1);
        send_vertex(32'hFFFF0000, 32'h80000000, 32'd0, 16'h4000, 16'd0, 16'd0, 16'd0,
                    16'h4000, 16'd0, 16'hFFFF);
        send_vertex(32'hFFFEFFFF, 32'h7FFFFFFF, 32'd1, 16'd0, 16'd0, 16'hC000, 16'd0, 16'd0,
                    16'h8000, 16'h8000);
        send_vertex(32'h00010000, 32'd0, 32'd2, 16'h8000, 16'h8000, 16'h8000,
                    16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_vertex(32'h0000FFFF, 32'h80000001, 32'hFFFFFFFF, 16'hC000, 16'h4000, 16'hF000,
                    16'h1000, 16'hF000, 16'h0000, 16'd1);
        send_vertex(32'h7FFFFFFF, 32'hFFFFFFFF, 32'h80000000, 16'd0, 16'hFFFF, 16'hFFFF,
                    16'd1, 16'd0, 16'hFFFF, 16'd0);
        send_vertex(32'hFFFF8000, 32'd3, 32'd0, 16'd1, 16'd1, 16'd1,
                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8001);
        drain();
        write_reg(REG_NONE, 32'hDEADBEEF);

        // Random phases over several boxes
        set_box(32'hFFF00000, 32'hFFFF0000, 32'h00100000, 32'h00200000, 32'h00020000, 32'd3);
        random_vertices(300, 32'hFFF00000, 32'h00200000);
        drain();

        // Long hold-off while the sender keeps offering
        fork
            hold_receiver(200);
            random_vertices(60, 32'hFFF00000, 32'h00200000);
        join
        drain();

        set_box(32'h80000000, 32'h80000000, 32'h80000000,
                32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        stall_mode = 2;
        random_vertices(150, 32'h80000000, 32'hFFFFFFFF);
        stall_mode = 0;
        drain();

        set_box(32'h7FFFFFFF, 32'h00000000, 32'hFFFFFFFF, 32'd0, 32'd1, 32'h00010000);
        random_vertices(250, 32'd0, 32'h00010000);
        drain();

        set_box(32'd1234, 32'hFFFFF000, 32'h00400000, 32'h00001000, 32'h80000000, 32'd65535);
        random_vertices(250, 32'd1234, 32'h00001000);
        drain();

        $display("covered %0d vertices and %0d records over five box settings", vertices,
                 records);
        $display("included zero extents, saturation, folds, zero vectors and a long stall");
        if (errors == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl
rtl/vaq_pkg.sv
rtl/vaq_cfg.sv
rtl/vaq_front.sv
rtl/vaq_div_step.sv
rtl/vertex_attribute_quantizer_unit.sv
bench/vertex_attribute_quantizer_unit_checker.sv
bench/vertex_attribute_quantizer_unit_test.sv
